@@ hdl/sfl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list package
// Shared codes, types and the size class function of the free block table.
// ----------------------------------------------------------------------------
package sfl_pkg;

   // Default table depth and number of power-of-two size classes.
   localparam int MAX_FREE_BLOCKS_DEF = 64;
   localparam int CLASS_COUNT_DEF     = 10;

   // Upper bound on the class count that the class field can encode.
   localparam int CLASS_COUNT_MAX = 16;

   // Size limit of the smallest class; class i holds sizes up to this << i.
   localparam int SMALLEST_CLASS_LIMIT = 32;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CLASS_W  = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2
   } sfl_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_FULL      = 2'd2,
      ST_DUPLICATE = 2'd3
   } sfl_status_type;

   // Contents of one table cell.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } sfl_entry_type;

   // Search token that travels from cell to cell, one cell per cycle.
   typedef struct packed {
      logic              live;
      logic              match;
      logic              fit;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } sfl_scan_type;

   // Controls that the sequencer drives to every cell at once.
   typedef struct packed {
      logic              insert;
      logic              kill;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } sfl_bcast_type;

   // Size class: the first class whose limit is at least the size, else the last.
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] sz,
                                                  input int count);
      logic [CLASS_W-1:0] cls;
      logic [SIZE_W:0]    lim;
      cls = CLASS_W'(count - 1);
      for (int i = CLASS_COUNT_MAX - 2; i >= 0; i--) begin
         lim = (SIZE_W + 1)'(SMALLEST_CLASS_LIMIT) << i;
         if ((i + 1 < count) && ({1'b0, sz} <= lim)) begin
            cls = CLASS_W'(i);
         end
      end
      return cls;
   endfunction

endpackage

@@ hdl/sfl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfl_pkg::CMD_W-1:0]     command;
   logic [sfl_pkg::ADDR_W-1:0]    block_address;
   logic [sfl_pkg::SIZE_W-1:0]    size;

   modport source (output valid, output command, output block_address, output size,
                   input ready);
   modport sink (input valid, input command, input block_address, input size,
                 output ready);
endinterface

interface sfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfl_pkg::STATUS_W-1:0]  status;
   logic [sfl_pkg::ADDR_W-1:0]    fit_address;
   logic [sfl_pkg::SIZE_W-1:0]    fit_size;
   logic [sfl_pkg::CLASS_W-1:0]   size_class;

   modport source (output valid, output status, output fit_address, output fit_size,
                   output size_class, input ready);
   modport sink (input valid, input status, input fit_address, input fit_size,
                 input size_class, output ready);
endinterface

@@ hdl/sfl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list cell
// One table entry with its share of the search and the compaction waves.
// ----------------------------------------------------------------------------
module sfl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sfl_pkg::sfl_bcast_type bcast,
   input  logic                   prev_valid,
   input  sfl_pkg::sfl_entry_type next_entry,
   output sfl_pkg::sfl_entry_type entry,
   input  sfl_pkg::sfl_scan_type  scan_from,
   output sfl_pkg::sfl_scan_type  scan_to,
   input  logic                   kill_from,
   output logic                   kill_to
);

   sfl_pkg::sfl_entry_type entry_ff, entry_in;
   sfl_pkg::sfl_scan_type  scan_ff, scan_in;
   logic                   kill_ff, kill_in;
   logic                   match;
   logic                   fits;

   // Local compares against the broadcast key.
   assign match = entry_ff.valid && (entry_ff.addr == bcast.addr);
   assign fits  = entry_ff.valid && (entry_ff.size >= bcast.size);

   // Fold this entry into the passing search token; a tie goes to the newer entry.
   always_comb begin
      scan_in = scan_from;
      if (scan_from.live) begin
         if (match) begin
            scan_in.match = 1'b1;
         end
         if (fits && (!scan_from.fit || (entry_ff.size <= scan_from.size))) begin
            scan_in.fit  = 1'b1;
            scan_in.size = entry_ff.size;
            scan_in.addr = entry_ff.addr;
         end
      end
   end

   // The removed entry and every later one take the upper neighbor, one per cycle.
   assign kill_in = (bcast.kill && match) || kill_from;

   // An insert lands in the first empty cell above the filled ones.
   always_comb begin
      entry_in = entry_ff;
      if (kill_in) begin
         entry_in = next_entry;
      end else if (bcast.insert && !entry_ff.valid && prev_valid) begin
         entry_in.valid = 1'b1;
         entry_in.addr  = bcast.addr;
         entry_in.size  = bcast.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         scan_ff.live   <= 1'b0;
         kill_ff        <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         scan_ff  <= scan_in;
         kill_ff  <= kill_in;
      end
   end

   assign entry   = entry_ff;
   assign scan_to = scan_ff;
   assign kill_to = kill_ff;

endmodule

@@ hdl/segregated_free_list_best_fit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list with best fit
// Free block table kept as a compacted row of cells in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_ch: insert a free block, remove a block by its
//   address, or find the best fit for a size. Every request gives exactly one
//   response on rsp_ch with a status, the chosen block for a find, and the
//   size class of the request size.
//   A request is taken only while no other request is in flight. A search
//   token then walks the row of MAX_FREE_BLOCKS cells, one cell per cycle.
//   A successful remove or find then sends a compaction wave up the row,
//   again one cell per cycle, that closes the gap. The response waits in an
//   output register; a stalled receiver holds it, while the next request is
//   still taken and worked on.
//   Reset (synchronous, active high) empties the table.
// ----------------------------------------------------------------------------
module segregated_free_list_best_fit #(
   parameter int MAX_FREE_BLOCKS = sfl_pkg::MAX_FREE_BLOCKS_DEF,
   parameter int CLASS_COUNT     = sfl_pkg::CLASS_COUNT_DEF
) (
   input logic      clock,
   input logic      reset,
   sfl_req_if.sink  req_ch,
   sfl_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_KILL,
      S_OUT
   } state_type;

   state_type                      state_ff, state_in;
   sfl_pkg::sfl_cmd_type           cmd_ff, cmd_in;
   logic [sfl_pkg::ADDR_W-1:0]     key_addr_ff, key_addr_in;
   logic [sfl_pkg::SIZE_W-1:0]     key_size_ff, key_size_in;
   logic                           scan_start_ff, scan_start_in;
   logic                           insert_ff, insert_in;
   logic                           kill_ff, kill_in;
   sfl_pkg::sfl_status_type        res_status_ff, res_status_in;
   logic [sfl_pkg::ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [sfl_pkg::SIZE_W-1:0]     res_size_ff, res_size_in;
   logic [sfl_pkg::CLASS_W-1:0]    res_class_ff, res_class_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sfl_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [sfl_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [sfl_pkg::SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [sfl_pkg::CLASS_W-1:0]    rsp_class_ff, rsp_class_in;

   sfl_pkg::sfl_bcast_type         bcast;
   sfl_pkg::sfl_scan_type          scan_head;
   sfl_pkg::sfl_scan_type          scan_tail;
   logic                           kill_tail;
   logic                           table_full;

   sfl_pkg::sfl_entry_type         cell_entry [MAX_FREE_BLOCKS];
   sfl_pkg::sfl_scan_type          cell_scan  [MAX_FREE_BLOCKS];
   logic                           cell_kill  [MAX_FREE_BLOCKS];

   // Broadcast controls and the fresh search token entering the first cell.
   assign bcast.insert = insert_ff;
   assign bcast.kill   = kill_ff;
   assign bcast.addr   = key_addr_ff;
   assign bcast.size   = key_size_ff;

   assign scan_head.live  = scan_start_ff;
   assign scan_head.match = 1'b0;
   assign scan_head.fit   = 1'b0;
   assign scan_head.size  = '0;
   assign scan_head.addr  = '0;

   assign scan_tail  = cell_scan[MAX_FREE_BLOCKS-1];
   assign kill_tail  = cell_kill[MAX_FREE_BLOCKS-1];
   assign table_full = cell_entry[MAX_FREE_BLOCKS-1].valid;

   // The row of cells; each one links to its lower and upper neighbor.
   for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
      sfl_pkg::sfl_entry_type nbr_next;
      sfl_pkg::sfl_scan_type  nbr_scan;
      logic                   nbr_prev_valid;
      logic                   nbr_kill;

      if (g == 0) begin : g_first
         assign nbr_prev_valid = 1'b1;
         assign nbr_scan       = scan_head;
         assign nbr_kill       = 1'b0;
      end else begin : g_rest
         assign nbr_prev_valid = cell_entry[g-1].valid;
         assign nbr_scan       = cell_scan[g-1];
         assign nbr_kill       = cell_kill[g-1];
      end

      if (g == MAX_FREE_BLOCKS - 1) begin : g_last
         assign nbr_next = '0;
      end else begin : g_inner
         assign nbr_next = cell_entry[g+1];
      end

      sfl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .prev_valid (nbr_prev_valid),
         .next_entry (nbr_next),
         .entry      (cell_entry[g]),
         .scan_from  (nbr_scan),
         .scan_to    (cell_scan[g]),
         .kill_from  (nbr_kill),
         .kill_to    (cell_kill[g])
      );
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   // Sequencer next values: take a request, run the search, update the table, respond.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_addr_in   = key_addr_ff;
      key_size_in   = key_size_ff;
      scan_start_in = 1'b0;
      insert_in     = 1'b0;
      kill_in       = 1'b0;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      res_class_in  = res_class_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_class_in  = rsp_class_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in        = sfl_pkg::sfl_cmd_type'(req_ch.command);
               key_addr_in   = req_ch.block_address;
               key_size_in   = req_ch.size;
               res_class_in  = sfl_pkg::class_of(req_ch.size, CLASS_COUNT);
               scan_start_in = 1'b1;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            if (scan_tail.live) begin
               res_status_in = sfl_pkg::ST_NONE;
               res_addr_in   = '0;
               res_size_in   = '0;
               state_in      = S_OUT;
               case (cmd_ff)
                  sfl_pkg::CMD_INSERT: begin
                     if (scan_tail.match) begin
                        res_status_in = sfl_pkg::ST_DUPLICATE;
                     end else if (table_full) begin
                        res_status_in = sfl_pkg::ST_FULL;
                     end else begin
                        res_status_in = sfl_pkg::ST_OK;
                        insert_in     = 1'b1;
                     end
                  end
                  sfl_pkg::CMD_REMOVE: begin
                     if (scan_tail.match) begin
                        res_status_in = sfl_pkg::ST_OK;
                        kill_in       = 1'b1;
                        state_in      = S_KILL;
                     end
                  end
                  sfl_pkg::CMD_FIND: begin
                     if (scan_tail.fit) begin
                        res_status_in = sfl_pkg::ST_OK;
                        res_addr_in   = scan_tail.addr;
                        res_size_in   = scan_tail.size;
                        key_addr_in   = scan_tail.addr;
                        kill_in       = 1'b1;
                        state_in      = S_KILL;
                     end
                  end
                  default: begin
                     res_status_in = sfl_pkg::ST_NONE;
                  end
               endcase
            end
         end

         S_KILL: begin
            if (kill_tail) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_size_in   = res_size_ff;
               rsp_class_in  = res_class_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_addr_ff   <= key_addr_in;
      key_size_ff   <= key_size_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      res_class_ff  <= res_class_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_class_ff  <= rsp_class_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_start_ff <= 1'b0;
         insert_ff     <= 1'b0;
         kill_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_start_ff <= scan_start_in;
         insert_ff     <= insert_in;
         kill_ff       <= kill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.fit_address = rsp_addr_ff;
   assign rsp_ch.fit_size    = rsp_size_ff;
   assign rsp_ch.size_class  = rsp_class_ff;

   // The search token leaves the row only while the sequencer waits for it.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      scan_tail.live |-> (state_ff == S_SCAN))
      else $error("search token left the row outside the search phase");

   // The compaction wave leaves the row only during the compaction phase.
   a_kill_end: assert property (@(posedge clock) disable iff (reset)
      kill_tail |-> (state_ff == S_KILL))
      else $error("compaction wave left the row outside the compaction phase");

   // One request never both inserts and removes a block.
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      !(insert_ff && kill_ff))
      else $error("insert and removal issued together");

   // Outside compaction, a filled cell 1 never sits above an empty cell 0.
   a_compact: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_KILL) |->
         !(cell_entry[1].valid && !cell_entry[0].valid))
      else $error("table lost its compaction at the bottom");

endmodule

@@ tb/segregated_free_list_best_fit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list checker
// Watches the request and response channels and keeps its own copy of the
// free block table. For every request transfer it works out the reply, and it
// compares every response transfer, field by field, with the oldest reply
// still due. The number of failures goes to the testbench top.
// ----------------------------------------------------------------------------
module segregated_free_list_best_fit_checker #(
   parameter int TABLE_DEPTH = sfl_pkg::MAX_FREE_BLOCKS_DEF,
   parameter int CLASSES     = sfl_pkg::CLASS_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   sfl_req_if   req_mon,
   sfl_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [sfl_pkg::ADDR_W-1:0] addr;
      logic [sfl_pkg::SIZE_W-1:0] size;
   } free_block_type;

   typedef struct packed {
      sfl_pkg::sfl_status_type     status;
      logic [sfl_pkg::ADDR_W-1:0]  fit_address;
      logic [sfl_pkg::SIZE_W-1:0]  fit_size;
      logic [sfl_pkg::CLASS_W-1:0] size_class;
   } alloc_reply_type;

   // Free blocks in insertion order, oldest first.
   free_block_type  free_blocks[$];
   // Replies still owed by the block, oldest first.
   alloc_reply_type replies_due[$];

   // Power-of-two bin of a size; the last bin takes everything larger.
   function automatic logic [sfl_pkg::CLASS_W-1:0] size_bin(
      input logic [sfl_pkg::SIZE_W-1:0] sz);
      longint unsigned ceiling;
      for (int i = 0; i < CLASSES - 1; i++) begin
         ceiling = longint'(sfl_pkg::SMALLEST_CLASS_LIMIT) << i;
         if (longint'(sz) <= ceiling) begin
            return sfl_pkg::CLASS_W'(i);
         end
      end
      return sfl_pkg::CLASS_W'(CLASSES - 1);
   endfunction

   // Apply one request to the table copy and return the reply it causes.
   function automatic alloc_reply_type predict_reply(
      input logic [sfl_pkg::CMD_W-1:0]  cmd,
      input logic [sfl_pkg::ADDR_W-1:0] addr,
      input logic [sfl_pkg::SIZE_W-1:0] sz);
      alloc_reply_type reply;
      int hit;
      int best;
      reply.status      = sfl_pkg::ST_NONE;
      reply.fit_address = '0;
      reply.fit_size    = '0;
      reply.size_class  = size_bin(sz);
      hit  = -1;
      best = -1;
      foreach (free_blocks[i]) begin
         if (hit < 0 && free_blocks[i].addr == addr) begin
            hit = i;
         end
      end
      case (cmd)
         sfl_pkg::CMD_INSERT: begin
            // A duplicate address is reported even when the table is full.
            if (hit >= 0) begin
               reply.status = sfl_pkg::ST_DUPLICATE;
            end else if (free_blocks.size() >= TABLE_DEPTH) begin
               reply.status = sfl_pkg::ST_FULL;
            end else begin
               free_blocks.push_back('{addr: addr, size: sz});
               reply.status = sfl_pkg::ST_OK;
            end
         end
         sfl_pkg::CMD_REMOVE: begin
            if (hit >= 0) begin
               free_blocks.delete(hit);
               reply.status = sfl_pkg::ST_OK;
            end
         end
         sfl_pkg::CMD_FIND: begin
            // Smallest block that holds the request; a tie goes to the newer one.
            foreach (free_blocks[i]) begin
               if (free_blocks[i].size >= sz &&
                   (best < 0 || free_blocks[i].size <= free_blocks[best].size)) begin
                  best = i;
               end
            end
            if (best >= 0) begin
               reply.fit_address = free_blocks[best].addr;
               reply.fit_size    = free_blocks[best].size;
               reply.status      = sfl_pkg::ST_OK;
               free_blocks.delete(best);
            end
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : watch_channels
      alloc_reply_type want;
      if (reset) begin
         free_blocks.delete();
         replies_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
               $error("response transfer with no reply due: status %0d", rsp_mon.status);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.fit_address !== want.fit_address) begin
                  $error("fit_address: expected %h, actual %h",
                         want.fit_address, rsp_mon.fit_address);
                  fail_count++;
               end
               if (rsp_mon.fit_size !== want.fit_size) begin
                  $error("fit_size: expected %h, actual %h", want.fit_size, rsp_mon.fit_size);
                  fail_count++;
               end
               if (rsp_mon.size_class !== want.size_class) begin
                  $error("size_class: expected %0d, actual %0d",
                         want.size_class, rsp_mon.size_class);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            replies_due.push_back(predict_reply(req_mon.command, req_mon.block_address,
                                                req_mon.size));
         end
      end
      pending = replies_due.size();
   end

endmodule

@@ tb/segregated_free_list_best_fit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated free list testbench
// Drives insert, remove and find requests into the free block table: a short
// directed opening on the corner cases, then random traffic in phases that
// fill, drain or mix the table, with random gaps on both channels, two long
// response stalls and pauses that let the block drain. A checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module segregated_free_list_best_fit_test;

   localparam int TABLE_DEPTH  = sfl_pkg::MAX_FREE_BLOCKS_DEF;
   localparam int CLASSES      = sfl_pkg::CLASS_COUNT_DEF;
   localparam int ITEM_GOAL    = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 10;
   localparam int POOL_DEPTH   = 48;
   localparam int MAX_GAP      = 14;

   localparam logic [sfl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfl_req_if req_ch();
   sfl_rsp_if rsp_ch();

   int fail_count;
   int pending;
   int item_count = 0;
   int idle_cycles = 0;
   bit tx_idle_en = 1'b0;
   bit rx_idle_en = 1'b0;
   bit rx_hold_req = 1'b0;

   logic [sfl_pkg::ADDR_W-1:0] addr_pool[POOL_DEPTH];
   logic [sfl_pkg::SIZE_W-1:0] size_pool[8];

   segregated_free_list_best_fit #(
      .MAX_FREE_BLOCKS(TABLE_DEPTH),
      .CLASS_COUNT(CLASSES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   segregated_free_list_best_fit_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .CLASSES(CLASSES)
   ) alloc_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #1 clock = ~clock;

   // Stall watchdog: counts cycles in which neither channel makes a transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Response side: random gaps per transfer, and one long hold when asked.
   initial begin : response_sink
      int gap;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
         @(negedge clock);
         if (rx_hold_req) begin
            gap = HOLD_CYCLES;
            rx_hold_req = 1'b0;
         end else begin
            gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // Offer one request after a random gap and wait for its transfer.
   task automatic send(input logic [sfl_pkg::CMD_W-1:0] cmd,
                       input logic [sfl_pkg::ADDR_W-1:0] addr,
                       input logic [sfl_pkg::SIZE_W-1:0] sz);
      int gap;
      gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.block_address <= addr;
      req_ch.size          <= sz;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready === 1'b1));
      @(negedge clock);
      item_count++;
   endtask

   // Stop offering and wait until every reply has come back.
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // Mostly addresses from a shared pool so removes and duplicates hit.
   function automatic logic [sfl_pkg::ADDR_W-1:0] pick_address(input int fresh_pct);
      if ($urandom_range(0, 99) < fresh_pct) begin
         return $urandom();
      end
      return addr_pool[$urandom_range(0, POOL_DEPTH - 1)];
   endfunction

   // Class edges, small sizes, full-range sizes and repeated sizes for ties.
   function automatic logic [sfl_pkg::SIZE_W-1:0] pick_size();
      logic [sfl_pkg::SIZE_W-1:0] edge_size;
      int roll;
      roll = $urandom_range(0, 99);
      edge_size = sfl_pkg::SIZE_W'(sfl_pkg::SMALLEST_CLASS_LIMIT)
                  << $urandom_range(0, CLASSES - 1);
      if (roll < 5) begin
         return '0;
      end else if (roll < 8) begin
         return '1;
      end else if (roll < 35) begin
         return edge_size + sfl_pkg::SIZE_W'($urandom_range(0, 2)) - 1;
      end else if (roll < 60) begin
         return $urandom_range(0, 20000);
      end else if (roll < 80) begin
         return $urandom();
      end
      return size_pool[$urandom_range(0, 7)];
   endfunction

   task automatic send_random(input traffic_mix_type mix);
      int roll;
      logic [sfl_pkg::CMD_W-1:0] cmd;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  cmd = roll < 80 ? sfl_pkg::CMD_INSERT : roll < 85 ? sfl_pkg::CMD_REMOVE :
                          roll < 95 ? sfl_pkg::CMD_FIND : CMD_UNUSED;
         MIX_DRAIN: cmd = roll < 15 ? sfl_pkg::CMD_INSERT : roll < 50 ? sfl_pkg::CMD_REMOVE :
                          roll < 95 ? sfl_pkg::CMD_FIND : CMD_UNUSED;
         default:   cmd = roll < 40 ? sfl_pkg::CMD_INSERT : roll < 65 ? sfl_pkg::CMD_REMOVE :
                          roll < 95 ? sfl_pkg::CMD_FIND : CMD_UNUSED;
      endcase
      send(cmd, pick_address(mix == MIX_FILL ? 70 : 25), pick_size());
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      traffic_mix_type mix;
      req_ch.valid         = 1'b0;
      req_ch.command       = sfl_pkg::CMD_INSERT;
      req_ch.block_address = '0;
      req_ch.size          = '0;
      foreach (addr_pool[i]) begin
         addr_pool[i] = $urandom();
      end
      foreach (size_pool[i]) begin
         size_pool[i] = $urandom_range(0, 10000);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: empty table, extremes, duplicates, ties and edges.
      send(sfl_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000);
      send(sfl_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0020);
      send(sfl_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
      send(sfl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(sfl_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0064);
      send(sfl_pkg::CMD_INSERT, 32'h0000_1000, 32'd32);
      send(sfl_pkg::CMD_INSERT, 32'h0000_2000, 32'd33);
      send(sfl_pkg::CMD_INSERT, 32'h0000_3000, 32'd64);
      send(sfl_pkg::CMD_INSERT, 32'h0000_4000, 32'd64);
      send(sfl_pkg::CMD_FIND, 32'h0000_0000, 32'd40);
      send(sfl_pkg::CMD_FIND, 32'h0000_0000, 32'd0);
      send(CMD_UNUSED, 32'h0000_2000, 32'd8192);
      send(sfl_pkg::CMD_REMOVE, 32'h0000_2000, 32'd0);
      send(sfl_pkg::CMD_REMOVE, 32'h0000_2000, 32'd0);
      send(sfl_pkg::CMD_FIND, 32'h5555_AAAA, 32'd8193);
      send(sfl_pkg::CMD_FIND, 32'hAAAA_5555, 32'hFFFF_FFFF);
      send(sfl_pkg::CMD_INSERT, 32'hA5A5_A5A5, 32'd8192);
      send(sfl_pkg::CMD_INSERT, 32'h5A5A_5A5A, 32'd8193);
      send(sfl_pkg::CMD_INSERT, 32'h0F0F_0F0F, 32'd4096);
      send(sfl_pkg::CMD_FIND, 32'h0000_0000, 32'd5000);
      send(sfl_pkg::CMD_FIND, 32'h0000_0000, 32'd4097);
      pause_until_drained();

      // Random phases; the second one fills the table past its depth.
      for (int phase = 0; item_count < ITEM_GOAL; phase++) begin
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         if (phase == 2 || phase == 9) begin
            rx_hold_req = 1'b1;
         end
         if (phase == 1) begin
            mix = MIX_FILL;
         end else begin
            mix = traffic_mix_type'($urandom_range(0, 2));
         end
         repeat (phase == 1 ? 110 : $urandom_range(40, 100)) send_random(mix);
         if (phase == 3 || $urandom_range(0, 2) == 0) begin
            pause_until_drained();
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
